FILE: rtl/infix_to_postfix_converter_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the infix to postfix converter
// Shared helpers that write clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define ITP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("infix_to_postfix_converter: assertion failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define ITP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("infix_to_postfix_converter: assertion failed");

`endif

FILE: rtl/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Constants, operator codes and lookup functions for the infix to postfix
// converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package itp_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned PTR_W       = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);

  // Character classes; the first six are also the codes kept on the stack.
  typedef enum logic [2:0] {
    OP_OPEN  = 3'd0,
    OP_PLUS  = 3'd1,
    OP_MINUS = 3'd2,
    OP_MUL   = 3'd3,
    OP_DIV   = 3'd4,
    OP_POW   = 3'd5,
    OP_CLOSE = 3'd6,
    OP_OTHER = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNMATCHED = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_UNCLOSED  = 2'd3
  } status_e;

  function automatic op_e op_classify(input logic [7:0] ch);
    op_e k;
    case (ch)
      8'h28:   k = OP_OPEN;
      8'h2B:   k = OP_PLUS;
      8'h2D:   k = OP_MINUS;
      8'h2A:   k = OP_MUL;
      8'h2F:   k = OP_DIV;
      8'h5E:   k = OP_POW;
      8'h29:   k = OP_CLOSE;
      default: k = OP_OTHER;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] op_char(input op_e k);
    logic [7:0] c;
    case (k)
      OP_PLUS:  c = 8'h2B;
      OP_MINUS: c = 8'h2D;
      OP_MUL:   c = 8'h2A;
      OP_DIV:   c = 8'h2F;
      OP_POW:   c = 8'h5E;
      default:  c = 8'h28;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] op_prec(input op_e k);
    logic [1:0] p;
    case (k)
      OP_PLUS, OP_MINUS: p = 2'd1;
      OP_MUL, OP_DIV:    p = 2'd2;
      OP_POW:            p = 2'd3;
      default:           p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter from an infix character stream to postfix beats.
// ----------------------------------------------------------------------------
// The block takes one ASCII character per input beat, with tlast on the final
// character of an expression, and returns the postfix form one character per
// output beat. Operands pass straight through, operators are reordered with an
// operator stack held in a small memory (STACK_DEPTH entries, set in the
// package), and the final character flushes the stack and closes the
// expression with an end beat that carries the status. The input is taken one
// character at a time and tready stays low until the character is done. An
// operand or an open goes from IDLE to FINISH. An operator or a close goes
// through READ, which reads the stack top out of the registered memory port,
// and EVAL, which compares its precedence and pushes the operator or drops
// the matching open; on an empty stack READ pushes the operator or flags a
// close as unmatched. Every operator popped off the stack takes another READ
// and EVAL, which stages it. The final character then flushes the stack
// with a READ and an EVAL for every operator it drains, until the stack is
// empty or an open stops it. After an error every character goes straight to
// FINISH. One character is staged so that the last beat of each character
// can be flagged; that beat moves out in FINISH. A full output register that
// is not taken stalls the sequencer until the sink accepts the beat.
// Errors (a close with no open, a stack overflow, an open left at the end) are
// reported in the status of the end beat; once one occurs no further
// characters are emitted until the expression ends. No clearing pass is
// needed after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module infix_to_postfix_converter (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Input characters.
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] ch
  input  logic       s_axis_tlast_i,   // last character of the expression
  // Postfix beats.
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_char
  output logic [3:0] m_axis_tuser_o,   // [0] has_char, [1] end_of_expr, [3:2] status
  output logic       m_axis_tlast_o    // run_last: last beat caused by this character
);

  localparam int unsigned DEPTH = itp_pkg::STACK_DEPTH;
  localparam int unsigned PTR_W = itp_pkg::PTR_W;
  localparam int unsigned CNT_W = itp_pkg::CNT_W;

  // IDLE waits for a character, READ fetches the stack top, EVAL decides on
  // a pop, FINISH delivers the staged character and closes the character.
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FINISH
  } state_e;

  state_e              state_q, state_d;
  itp_pkg::op_e        kind_q, kind_d;
  logic                last_q, last_d;
  logic                flush_q, flush_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  itp_pkg::status_e    err_q, err_d;
  logic                pend_vld_q, pend_vld_d;
  logic [7:0]          pend_char_q, pend_char_d;
  logic                m_valid_q, m_valid_d;

  // Output register payload.
  logic [7:0]          out_char_q, out_char_n;
  logic                out_has_q, out_has_n;
  logic                out_end_q, out_end_n;
  itp_pkg::status_e    out_status_q, out_status_n;
  logic                out_last_q, out_last_n;
  logic                out_load;

  // Operator stack memory with a registered read port.
  itp_pkg::op_e        stack_mem [DEPTH];
  itp_pkg::op_e        rd_q;
  logic                rd_en;
  logic                mem_we;
  logic [PTR_W-1:0]    mem_waddr;
  itp_pkg::op_e        mem_wdata;
  logic [CNT_W-1:0]    cnt_m1;

  logic                in_beat;
  logic                out_free;
  itp_pkg::op_e        kind_in;

  assign in_beat  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign kind_in  = itp_pkg::op_classify(s_axis_tdata_i);
  assign cnt_m1   = cnt_q - CNT_W'(1);

  always_comb begin
    logic         push_req;
    logic         post_req;
    logic         pop_req;
    itp_pkg::op_e push_code;
    logic         cur_last;

    push_req  = 1'b0;
    post_req  = 1'b0;
    pop_req   = 1'b0;
    push_code = kind_q;
    cur_last  = last_q;

    state_d     = state_q;
    kind_d      = kind_q;
    last_d      = last_q;
    flush_d     = flush_q;
    cnt_d       = cnt_q;
    err_d       = err_q;
    pend_vld_d  = pend_vld_q;
    pend_char_d = pend_char_q;

    rd_en     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cnt_q[PTR_W-1:0];
    mem_wdata = push_code;

    out_load     = 1'b0;
    out_char_n   = pend_char_q;
    out_has_n    = 1'b1;
    out_end_n    = 1'b0;
    out_status_n = itp_pkg::ST_OK;
    out_last_n   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          kind_d   = kind_in;
          last_d   = s_axis_tlast_i;
          flush_d  = 1'b0;
          cur_last = s_axis_tlast_i;
          if (err_q != itp_pkg::ST_OK) begin
            post_req = 1'b1;
          end else if (kind_in == itp_pkg::OP_OTHER) begin
            // Operands go straight to the staging register.
            pend_vld_d  = 1'b1;
            pend_char_d = s_axis_tdata_i;
            post_req    = 1'b1;
          end else if (kind_in == itp_pkg::OP_OPEN) begin
            push_req  = 1'b1;
            push_code = itp_pkg::OP_OPEN;
            post_req  = 1'b1;
          end else begin
            state_d = S_READ;
          end
        end
      end

      S_READ: begin
        if (cnt_q != '0) begin
          rd_en   = 1'b1;
          state_d = S_EVAL;
        end else if (flush_q) begin
          state_d = S_FINISH;
        end else if (kind_q == itp_pkg::OP_CLOSE) begin
          err_d    = itp_pkg::ST_UNMATCHED;
          post_req = 1'b1;
        end else begin
          push_req = 1'b1;
          post_req = 1'b1;
        end
      end

      S_EVAL: begin
        if (flush_q) begin
          if (rd_q == itp_pkg::OP_OPEN) begin
            err_d   = itp_pkg::ST_UNCLOSED;
            state_d = S_FINISH;
          end else begin
            pop_req = 1'b1;
          end
        end else if (kind_q == itp_pkg::OP_CLOSE) begin
          if (rd_q == itp_pkg::OP_OPEN) begin
            // The matching open is dropped.
            cnt_d    = cnt_m1;
            post_req = 1'b1;
          end else begin
            pop_req = 1'b1;
          end
        end else begin
          // '^' binds to the right, the other operators to the left.
          if ((rd_q != itp_pkg::OP_OPEN) &&
              ((itp_pkg::op_prec(rd_q) > itp_pkg::op_prec(kind_q)) ||
               ((itp_pkg::op_prec(rd_q) == itp_pkg::op_prec(kind_q)) &&
                (kind_q != itp_pkg::OP_POW)))) begin
            pop_req = 1'b1;
          end else begin
            push_req = 1'b1;
            post_req = 1'b1;
          end
        end

        if (pop_req && (!pend_vld_q || out_free)) begin
          if (pend_vld_q) begin
            out_load = 1'b1;
          end
          pend_vld_d  = 1'b1;
          pend_char_d = itp_pkg::op_char(rd_q);
          cnt_d       = cnt_m1;
          state_d     = S_READ;
        end
      end

      S_FINISH: begin
        if (pend_vld_q || last_q) begin
          if (out_free) begin
            out_load     = 1'b1;
            out_char_n   = pend_vld_q ? pend_char_q : 8'h00;
            out_has_n    = pend_vld_q;
            out_end_n    = last_q;
            out_status_n = last_q ? err_q : itp_pkg::ST_OK;
            out_last_n   = 1'b1;
            pend_vld_d   = 1'b0;
            if (last_q) begin
              cnt_d = '0;
              err_d = itp_pkg::ST_OK;
            end
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A push onto a full stack drops the item and records an overflow.
    if (push_req) begin
      mem_wdata = push_code;
      if (cnt_q == CNT_W'(DEPTH)) begin
        if (err_d == itp_pkg::ST_OK) begin
          err_d = itp_pkg::ST_OVERFLOW;
        end
      end else begin
        mem_we = 1'b1;
        cnt_d  = cnt_q + CNT_W'(1);
      end
    end

    // After the character's own work, the final one flushes the stack.
    if (post_req) begin
      if (cur_last && (err_d == itp_pkg::ST_OK)) begin
        flush_d = 1'b1;
        state_d = S_READ;
      end else begin
        state_d = S_FINISH;
      end
    end

    m_valid_d = out_load || (m_valid_q && !m_axis_tready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      kind_q     <= itp_pkg::OP_OTHER;
      last_q     <= 1'b0;
      flush_q    <= 1'b0;
      cnt_q      <= '0;
      err_q      <= itp_pkg::ST_OK;
      pend_vld_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      kind_q     <= kind_d;
      last_q     <= last_d;
      flush_q    <= flush_d;
      cnt_q      <= cnt_d;
      err_q      <= err_d;
      pend_vld_q <= pend_vld_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_char_q <= pend_char_d;
    if (out_load) begin
      out_char_q   <= out_char_n;
      out_has_q    <= out_has_n;
      out_end_q    <= out_end_n;
      out_status_q <= out_status_n;
      out_last_q   <= out_last_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_q <= stack_mem[cnt_m1[PTR_W-1:0]];
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_char_q;
  assign m_axis_tuser_o  = {out_status_q, out_end_q, out_has_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

FILE: rtl/itp_checker.sv
// ----------------------------------------------------------------------------
// itp_checker
// Port-level checks for the infix to postfix converter, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "infix_to_postfix_converter_defines.svh"

module itp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic [7:0] s_axis_tdata_i,
  input logic       s_axis_tlast_i,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic [3:0] m_axis_tuser_o,
  input logic       m_axis_tlast_o
);

  logic [8:0]  in_beat;
  logic [12:0] out_beat;
  logic        out_has;
  logic        out_end;
  logic [1:0]  out_status;

  assign in_beat    = {s_axis_tlast_i, s_axis_tdata_i};
  assign out_beat   = {m_axis_tlast_o, m_axis_tuser_o, m_axis_tdata_o};
  assign out_has    = m_axis_tuser_o[0];
  assign out_end    = m_axis_tuser_o[1];
  assign out_status = m_axis_tuser_o[3:2];

  // An offered character that is not taken stays on the bus unchanged.
  `ITP_ASSERT_NEXT(a_in_hold, s_axis_tvalid_i && !s_axis_tready_o, s_axis_tvalid_i && $stable(in_beat))

  // A stalled beat must hold until the sink takes it.
  `ITP_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(out_beat))

  // A beat without a character only closes an expression, and carries zero.
  `ITP_ASSERT_NOW(a_empty_is_end, m_axis_tvalid_o && !out_has, out_end && m_axis_tlast_o && (m_axis_tdata_o == 8'h00))

  // A nonzero status only appears on the end beat, which ends its character.
  `ITP_ASSERT_NOW(a_status_on_end, m_axis_tvalid_o && ((out_status != 2'(itp_pkg::ST_OK)) || out_end), out_end && m_axis_tlast_o)

  // A new character is never taken while an earlier one has beats to come.
  `ITP_ASSERT_NOW(a_no_accept_mid_run, m_axis_tvalid_o && !m_axis_tlast_o, !s_axis_tready_o)

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (.*);
